>>> hdl/imgrot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imgrot_pkg;

   // Frame geometry
   localparam int MAX_DIM         = 64;
   localparam int MAX_CHANNELS    = 4;
   localparam int DIM_W           = $clog2(MAX_DIM);          // row / column index
   localparam int SIZE_W          = DIM_W + 1;                // size 1..MAX_DIM
   localparam int CH_W            = $clog2(MAX_CHANNELS);     // channel index
   localparam int CHCNT_W         = CH_W + 1;                 // channel count 1..MAX_CHANNELS
   localparam int PIX_W           = 2 * DIM_W;                // pixel index
   localparam int ADDR_W          = PIX_W + CH_W;             // sample address
   localparam int TOTAL_W         = ADDR_W + 1;               // sample count
   localparam int STORE_DEPTH     = MAX_DIM * MAX_DIM * MAX_CHANNELS;
   localparam int DATA_W          = 32;                       // sample port width
   localparam int SAMPLE_BITS_DEF = 32;

   // Configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd3;

   // Rotation codes
   localparam logic [1:0] ROT_90   = 2'd0;
   localparam logic [1:0] ROT_180  = 2'd1;
   localparam logic [1:0] ROT_270  = 2'd2;
   localparam logic [1:0] ROT_NONE = 2'd3;

   // Request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0]  height;   // clamped 1..MAX_DIM
      logic [SIZE_W-1:0]  width;    // clamped 1..MAX_DIM
      logic [CHCNT_W-1:0] chans;    // clamped 1..MAX_CHANNELS
      logic [1:0]         rot;
      logic [TOTAL_W-1:0] total;    // samples per frame
   } cfg_type;

   typedef struct packed {
      logic              is_load;
      logic [ADDR_W-1:0] load_addr;
      logic [DATA_W-1:0] data;
      logic [DIM_W-1:0]  src_r;
      logic [DIM_W-1:0]  src_c;
      logic [DIM_W-1:0]  row;
      logic [DIM_W-1:0]  col;
      logic [CH_W-1:0]   chan;
      logic              last;
   } s1_type;

   typedef struct packed {
      logic              is_load;
      logic [ADDR_W-1:0] load_addr;
      logic [DATA_W-1:0] data;
      logic [PIX_W-1:0]  pix;
      logic [DIM_W-1:0]  row;
      logic [DIM_W-1:0]  col;
      logic [CH_W-1:0]   chan;
      logic              last;
   } s2_type;

   function automatic logic [SIZE_W-1:0] clamp_dim(logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_DIM)) begin
         return SIZE_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic logic [CHCNT_W-1:0] clamp_chans(logic [CHCNT_W-1:0] v);
      if (v == '0) begin
         return CHCNT_W'(1);
      end else if (v > CHCNT_W'(MAX_CHANNELS)) begin
         return CHCNT_W'(MAX_CHANNELS);
      end
      return v;
   endfunction

   // Multiply by a channel count of 1..4 with shifts and at most one add
   function automatic logic [TOTAL_W-1:0] times_chans(logic [TOTAL_W-1:0] x,
                                                      logic [CHCNT_W-1:0] c);
      logic [TOTAL_W-1:0] r;
      case (c)
         CHCNT_W'(2): r = x << 1;
         CHCNT_W'(3): r = x + (x << 1);
         CHCNT_W'(4): r = x << 2;
         default:     r = x;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/imgrot_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module imgrot_csr
   import imgrot_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output cfg_type                   cfg
);

   localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(MAX_DIM * MAX_DIM);

   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [SIZE_W-1:0]  width_ff,  width_in;
   logic [CHCNT_W-1:0] chans_ff,  chans_in;
   logic [1:0]         rot_ff,    rot_in;
   logic [TOTAL_W-1:0] total_ff,  total_in;
   logic [TOTAL_W-1:0] area;

   // Sizes are held clamped; the frame size follows each write.
   always_comb begin
      height_in = height_ff;
      width_in  = width_ff;
      chans_in  = chans_ff;
      rot_in    = rot_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HEIGHT:   height_in = clamp_dim(csr_wdata[SIZE_W-1:0]);
            CSR_WIDTH:    width_in  = clamp_dim(csr_wdata[SIZE_W-1:0]);
            CSR_ROTATION: rot_in    = csr_wdata[1:0];
            CSR_CHANNELS: chans_in  = clamp_chans(csr_wdata[CHCNT_W-1:0]);
            default: ;
         endcase
      end
      area     = TOTAL_W'(height_in) * TOTAL_W'(width_in);
      total_in = times_chans(area, chans_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= SIZE_W'(MAX_DIM);
         width_ff  <= SIZE_W'(MAX_DIM);
         chans_ff  <= CHCNT_W'(1);
         rot_ff    <= ROT_90;
         total_ff  <= TOTAL_RST;
      end else begin
         height_ff <= height_in;
         width_ff  <= width_in;
         chans_ff  <= chans_in;
         rot_ff    <= rot_in;
         total_ff  <= total_in;
      end
   end

   assign cfg.height = height_ff;
   assign cfg.width  = width_ff;
   assign cfg.chans  = chans_ff;
   assign cfg.rot    = rot_ff;
   assign cfg.total  = total_ff;

endmodule

`default_nettype wire

>>> hdl/imgrot_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module imgrot_seq
   import imgrot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              adv,
   input  wire logic              take,
   input  wire logic              req_mode,
   input  wire logic [DATA_W-1:0] req_sample_in,
   output logic                   s1_valid,
   output s1_type                 s1
);

   logic [ADDR_W-1:0]  load_count_ff, load_count_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   col_ff, col_in;
   logic [CH_W-1:0]    chan_ff, chan_in;
   logic               s1_valid_ff, s1_valid_in;
   s1_type             s1_ff, s1_in;

   logic [ADDR_W-1:0]  load_idx;
   logic [TOTAL_W-1:0] load_nxt;
   logic [SIZE_W-1:0]  out_h, out_w;
   logic               restart, is_fetch, is_load;
   logic [DIM_W-1:0]   row, col;
   logic [CH_W-1:0]    chan;
   logic               row_last, col_last, chan_last;
   logic [SIZE_W-1:0]  src_r, src_c;

   always_comb begin
      is_load  = take && (req_mode == MODE_LOAD);
      is_fetch = take && (req_mode == MODE_FETCH) && (cfg.rot != ROT_NONE);

      // load counter, restarted if the frame shrank
      load_idx = (TOTAL_W'(load_count_ff) >= cfg.total) ? '0 : load_count_ff;
      load_nxt = TOTAL_W'(load_idx) + TOTAL_W'(1);
      load_count_in = load_count_ff;
      if (is_load) begin
         load_count_in = (load_nxt >= cfg.total) ? '0 : load_nxt[ADDR_W-1:0];
      end

      // output geometry
      out_h = (cfg.rot == ROT_180) ? cfg.height : cfg.width;
      out_w = (cfg.rot == ROT_180) ? cfg.width  : cfg.height;
      restart = (SIZE_W'(row_ff) >= out_h) || (SIZE_W'(col_ff) >= out_w) ||
                (CHCNT_W'(chan_ff) >= cfg.chans);
      row  = restart ? '0 : row_ff;
      col  = restart ? '0 : col_ff;
      chan = restart ? '0 : chan_ff;

      row_last  = (SIZE_W'(row)   == out_h - SIZE_W'(1));
      col_last  = (SIZE_W'(col)   == out_w - SIZE_W'(1));
      chan_last = (CHCNT_W'(chan) == cfg.chans - CHCNT_W'(1));

      case (cfg.rot)
         ROT_90: begin
            src_r = cfg.height - SIZE_W'(1) - SIZE_W'(col);
            src_c = SIZE_W'(row);
         end
         ROT_180: begin
            src_r = cfg.height - SIZE_W'(1) - SIZE_W'(row);
            src_c = cfg.width  - SIZE_W'(1) - SIZE_W'(col);
         end
         default: begin
            src_r = SIZE_W'(col);
            src_c = cfg.width - SIZE_W'(1) - SIZE_W'(row);
         end
      endcase

      row_in  = row_ff;
      col_in  = col_ff;
      chan_in = chan_ff;
      if (is_fetch) begin
         chan_in = chan_last ? '0 : chan + CH_W'(1);
         col_in  = chan_last ? (col_last ? '0 : col + DIM_W'(1)) : col;
         row_in  = (chan_last && col_last) ? (row_last ? '0 : row + DIM_W'(1)) : row;
      end

      s1_valid_in     = is_load || is_fetch;
      s1_in.is_load   = is_load;
      s1_in.load_addr = load_idx;
      s1_in.data      = req_sample_in;
      s1_in.src_r     = src_r[DIM_W-1:0];
      s1_in.src_c     = src_c[DIM_W-1:0];
      s1_in.row       = row;
      s1_in.col       = col;
      s1_in.chan      = chan;
      s1_in.last      = row_last && col_last && chan_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         chan_ff       <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         chan_ff       <= chan_in;
         if (adv) begin
            s1_valid_ff <= s1_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

`default_nettype wire

>>> hdl/imgrot_addr.sv
`timescale 1ns / 1ps
`default_nettype none

module imgrot_addr
   import imgrot_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    adv,
   input  wire cfg_type cfg,
   input  wire logic    s1_valid,
   input  wire s1_type  s1,
   output logic         s2_valid,
   output s2_type       s2
);

   localparam int PROD_W = DIM_W + SIZE_W;

   logic [PROD_W-1:0] pix_wide;
   logic              s2_valid_ff;
   s2_type            s2_ff, s2_in;

   // source pixel index = row * width + column
   always_comb begin
      pix_wide        = PROD_W'(s1.src_r) * PROD_W'(cfg.width) + PROD_W'(s1.src_c);
      s2_in.is_load   = s1.is_load;
      s2_in.load_addr = s1.load_addr;
      s2_in.data      = s1.data;
      s2_in.pix       = pix_wide[PIX_W-1:0];
      s2_in.row       = s1.row;
      s2_in.col       = s1.col;
      s2_in.chan      = s1.chan;
      s2_in.last      = s1.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

`default_nettype wire

>>> hdl/imgrot_store.sv
`timescale 1ns / 1ps
`default_nettype none

module imgrot_store
   import imgrot_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire cfg_type           cfg,
   input  wire logic              s2_valid,
   input  wire s2_type            s2,
   output logic                   rsp_valid,
   output logic [DATA_W-1:0]      rsp_sample_out,
   output logic [DIM_W-1:0]       rsp_out_row,
   output logic [DIM_W-1:0]       rsp_out_col,
   output logic [CH_W-1:0]        rsp_out_channel,
   output logic                   rsp_frame_last
);

   logic [SAMPLE_BITS-1:0] frame_mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rdata_ff;
   logic                   rsp_valid_ff;
   logic [DIM_W-1:0]       row_ff, col_ff;
   logic [CH_W-1:0]        chan_ff;
   logic                   last_ff;
   logic [TOTAL_W-1:0]     scaled;
   logic [ADDR_W-1:0]      addr;

   always_comb begin
      scaled = times_chans(TOTAL_W'(s2.pix), cfg.chans);
      addr   = s2.is_load ? s2.load_addr : scaled[ADDR_W-1:0] + ADDR_W'(s2.chan);
   end

   // single-port frame store: a load writes, a fetch reads
   always_ff @(posedge clock) begin
      if (adv && s2_valid) begin
         if (s2.is_load) begin
            frame_mem[addr] <= s2.data[SAMPLE_BITS-1:0];
         end else begin
            rdata_ff <= frame_mem[addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid && !s2.is_load;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s2_valid && !s2.is_load) begin
         row_ff  <= s2.row;
         col_ff  <= s2.col;
         chan_ff <= s2.chan;
         last_ff <= s2.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = DATA_W'(rdata_ff);
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_out_channel = chan_ff;
   assign rsp_frame_last  = last_ff;

endmodule

`default_nettype wire

>>> hdl/image_rotate_nx90_core.sv
// Path: a fetch passes the stage 1, stage 2 and output registers before rsp_valid.
// Throughput: one transfer per cycle unless stalled, loads and fetches mixed freely;
//   the frame store has one port, used once by each item in the same pipeline stage.
// Back-pressure: the whole pipeline holds while a response waits on rsp_ready.
// Reset: synchronous, active high; config to defaults; counters, valid flags cleared.
//   The frame store is not cleared; there is no start-up sweep.
`timescale 1ns / 1ps
`default_nettype none

module image_rotate_nx90_core
   import imgrot_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF   // stored bits per sample, 8..32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_mode,
   input  wire logic [DATA_W-1:0]    req_sample_in,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [DATA_W-1:0]         rsp_sample_out,
   output logic [DIM_W-1:0]          rsp_out_row,
   output logic [DIM_W-1:0]          rsp_out_col,
   output logic [CH_W-1:0]           rsp_out_channel,
   output logic                      rsp_frame_last,
   // configuration writes
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type cfg;
   logic    adv;          // pipeline moves this cycle
   logic    take;         // request transfer
   logic    s1_valid, s2_valid;
   s1_type  s1;
   s2_type  s2;

   // The output register is the only place a result can wait, so the
   // pipeline steps whenever it is empty or being drained.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign take      = req_valid && req_ready;

   // Register file: sizes clamped on write, frame sample count kept alongside.
   imgrot_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Stage 1: load write counter and output raster counters; maps the
   // output position back to its source row and column.
   imgrot_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .adv           (adv),
      .take          (take),
      .req_mode      (req_mode),
      .req_sample_in (req_sample_in),
      .s1_valid      (s1_valid),
      .s1            (s1)
   );

   // Stage 2: source pixel index (row times width plus column).
   imgrot_addr u_addr (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   // Stage 3: channel scaling, frame store access and the output register.
   imgrot_store #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .cfg             (cfg),
      .s2_valid        (s2_valid),
      .s2              (s2),
      .rsp_valid       (rsp_valid),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_channel (rsp_out_channel),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

`default_nettype wire

>>> hdl/imgrot_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module imgrot_chk
   import imgrot_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DATA_W-1:0]    rsp_sample_out,
   input wire logic [DIM_W-1:0]     rsp_out_row,
   input wire logic [DIM_W-1:0]     rsp_out_col,
   input wire logic [CH_W-1:0]      rsp_out_channel,
   input wire logic                 rsp_frame_last
);

   // next response must start a frame (after reset or a last sample)
   logic             origin_ff;
   logic [DIM_W-1:0] prev_row_ff, prev_col_ff;
   logic [CH_W-1:0]  prev_chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         origin_ff <= rsp_frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_row_ff  <= rsp_out_row;
         prev_col_ff  <= rsp_out_col;
         prev_chan_ff <= rsp_out_channel;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) &&
         $stable(rsp_out_row) && $stable(rsp_out_col) &&
         $stable(rsp_out_channel) && $stable(rsp_frame_last))
      else $error("response changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output register");

   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && origin_ff |->
         rsp_out_row == '0 && rsp_out_col == '0 && rsp_out_channel == '0)
      else $error("frame does not start at the origin");

   a_chan_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !origin_ff && rsp_out_channel != '0 |->
         prev_chan_ff == rsp_out_channel - CH_W'(1) &&
         prev_row_ff == rsp_out_row && prev_col_ff == rsp_out_col)
      else $error("channel sequence broken within a pixel");

endmodule

bind image_rotate_nx90_core imgrot_chk u_imgrot_chk (.*);

`default_nettype wire
